// ===== hdl/icc_pkg.sv =====
// Package for the identifier case converter.
// Holds style codes, character constants, result struct and ASCII case helpers.
// No dependencies.
`default_nettype none
package icc_pkg;

    typedef enum logic [3:0] {
        STYLE_UPPER    = 4'd0,
        STYLE_LOWER    = 4'd1,
        STYLE_TITLE    = 4'd2,
        STYLE_CAMEL    = 4'd3,
        STYLE_SNAKE    = 4'd4,
        STYLE_CONSTANT = 4'd5,
        STYLE_KEBAB    = 4'd6,
        STYLE_PASCAL   = 4'd7,
        STYLE_PASS     = 4'd8
    } t_style;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_HYPHEN     = 8'h2D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NONE       = 8'h00;
    localparam logic [7:0] CASE_DELTA    = 8'h20;

    // One result transaction.
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
        logic       text_done;
    } t_res;

    function automatic logic is_up(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_low(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    function automatic logic [7:0] to_up(input logic [7:0] c);
        return is_low(c) ? (c - CASE_DELTA) : c;
    endfunction

    function automatic logic [7:0] to_low(input logic [7:0] c);
        return is_up(c) ? (c + CASE_DELTA) : c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/icc_if.sv =====
// Stream interfaces for the identifier case converter.
// Input channel carries one text byte; output channel carries one result.
// No dependencies.
`default_nettype none
interface icc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       text_end;

    modport source (output valid, output in_char, output text_end, input ready);
    modport sink   (input valid, input in_char, input text_end, output ready);
endinterface

interface icc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_char, output char_valid,
                    output run_last, output text_done, input ready);
    modport sink   (input valid, input out_char, input char_valid,
                    input run_last, input text_done, output ready);
endinterface
`default_nettype wire

// ===== hdl/identifier_case_converter.sv =====
// Identifier case converter top level.
// Depends on icc_pkg and the stream interfaces in icc_if.sv.
//
// Usage:
//   i_in  : byte stream (in_char, text_end). text_end marks the last byte of
//           a text; word tracking clears after it.
//   o_out : result stream (out_char, char_valid, run_last, text_done). One
//           input byte gives zero, one or two result transactions; run_last
//           flags the last result of a byte, text_done the last of a text.
//           A dropped separator at text end gives one empty result
//           (char_valid 0).
//   i_cfg_we / i_cfg_wdata : style register, written only while idle by the
//           user; the block does not enforce this.
// Each byte passes the input stage, then the result buffer if it gives results.
// Throughput: one byte per cycle while o_out.ready is high; a byte that
//   inserts a word separator fills the two-entry result buffer, and the
//   next byte waits for it to drain at the one-result-per-cycle output port.
// Reset: synchronous active low; style returns to passthrough, word state,
//   input stage and result buffer clear. Ready is low during reset.
// Stall: when o_out.ready is low the buffered results hold; the input
//   stage fills and then i_in.ready drops until the buffer drains.
`default_nettype none
module identifier_case_converter (
    input  wire        i_clk,
    input  wire        i_rst_n,
    icc_in_if.sink     i_in,
    icc_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [3:0]  i_cfg_wdata
);
    import icc_pkg::*;

    // style register
    logic [3:0] r_style;

    // input stage
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_end;

    // word tracking state
    logic r_prev_lower, r_in_word, r_word_seen;
    logic n_prev_lower, n_in_word, n_word_seen;

    // result buffer: r_res0 is presented, r_res1 follows
    logic [1:0] r_cnt;
    t_res       r_res0, r_res1;
    t_res       n_res0, n_res1;
    logic [1:0] n_cnt;

    logic sep, starts, first_word, word_style, has_joint, emit_joint, cap;
    logic emit_main, emit_empty;
    logic [7:0] joint, main_char;
    logic out_fire, out_free, s1_adv, in_fire;

    assign out_fire = (r_cnt != 2'd0) && o_out.ready;
    assign out_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_fire);

    // Decode the registered byte against the tracked word state.
    always_comb begin
        sep        = (r_s1_char == CH_UNDERSCORE) || (r_s1_char == CH_HYPHEN) ||
                     (r_s1_char == CH_SPACE);
        first_word = !r_word_seen;
        // upper after lower opens a new word (camel-hump boundary)
        starts     = !sep && (!r_in_word || (is_up(r_s1_char) && r_prev_lower));

        n_in_word    = !sep;
        n_word_seen  = r_word_seen | starts;
        n_prev_lower = is_low(r_s1_char);
        if (r_s1_end) begin
            n_in_word    = 1'b0;
            n_word_seen  = 1'b0;
            n_prev_lower = 1'b0;
        end

        word_style = 1'b0;
        has_joint  = 1'b0;
        joint      = CH_NONE;
        cap        = 1'b0;
        main_char  = r_s1_char;
        case (r_style)
            STYLE_UPPER: main_char = to_up(r_s1_char);
            STYLE_LOWER: main_char = to_low(r_s1_char);
            STYLE_TITLE: begin
                word_style = 1'b1;
                has_joint  = 1'b1;
                joint      = CH_SPACE;
                cap        = starts;
            end
            STYLE_CAMEL: begin
                word_style = 1'b1;
                cap        = starts && !first_word;
            end
            STYLE_SNAKE: begin
                word_style = 1'b1;
                has_joint  = 1'b1;
                joint      = CH_UNDERSCORE;
            end
            STYLE_CONSTANT: begin
                word_style = 1'b1;
                has_joint  = 1'b1;
                joint      = CH_UNDERSCORE;
                cap        = 1'b1;
            end
            STYLE_KEBAB: begin
                word_style = 1'b1;
                has_joint  = 1'b1;
                joint      = CH_HYPHEN;
            end
            STYLE_PASCAL: begin
                word_style = 1'b1;
                cap        = starts;
            end
            default: main_char = r_s1_char;  // passthrough and unused codes
        endcase
        if (word_style) begin
            main_char = cap ? to_up(r_s1_char) : to_low(r_s1_char);
        end

        emit_joint = word_style && has_joint && starts && !first_word;
        emit_main  = !(word_style && sep);
        emit_empty = !emit_main && r_s1_end;
    end

    // Dropped bytes never need buffer space.
    assign s1_adv  = r_s1_valid && (out_free || (!emit_main && !emit_empty));
    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && (!r_s1_valid || s1_adv);

    // Next buffer contents.
    always_comb begin
        n_res0 = r_res0;
        n_res1 = r_res1;
        n_cnt  = r_cnt;
        if (out_fire) begin
            n_res0 = r_res1;
            n_cnt  = r_cnt - 2'd1;
        end
        if (s1_adv && (emit_main || emit_empty)) begin
            if (emit_joint) begin
                n_res0 = '{out_char: joint, char_valid: 1'b1, run_last: 1'b0,
                           text_done: 1'b0};
                n_res1 = '{out_char: main_char, char_valid: 1'b1, run_last: 1'b1,
                           text_done: r_s1_end};
                n_cnt  = 2'd2;
            end else if (emit_main) begin
                n_res0 = '{out_char: main_char, char_valid: 1'b1, run_last: 1'b1,
                           text_done: r_s1_end};
                n_cnt  = 2'd1;
            end else begin
                n_res0 = '{out_char: CH_NONE, char_valid: 1'b0, run_last: 1'b1,
                           text_done: 1'b1};
                n_cnt  = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_style      <= STYLE_PASS;
            r_s1_valid   <= 1'b0;
            r_prev_lower <= 1'b0;
            r_in_word    <= 1'b0;
            r_word_seen  <= 1'b0;
            r_cnt        <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_style <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_prev_lower <= n_prev_lower;
                r_in_word    <= n_in_word;
                r_word_seen  <= n_word_seen;
            end
            r_cnt <= n_cnt;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_char <= i_in.in_char;
            r_s1_end  <= i_in.text_end;
        end
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.out_char   = r_res0.out_char;
    assign o_out.char_valid = r_res0.char_valid;
    assign o_out.run_last   = r_res0.run_last;
    assign o_out.text_done  = r_res0.text_done;

endmodule
`default_nettype wire

// ===== hdl/icc_checker.sv =====
// Port-level checker for the identifier case converter, with its bind.
// Depends on the top level identifier_case_converter.
`default_nettype none
module icc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_char,
    input wire       i_char_valid,
    input wire       i_run_last,
    input wire       i_text_done
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_char_valid) && $stable(i_run_last) && $stable(i_text_done))
        else $error("result changed while stalled");

    // empty result only closes a text
    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_char_valid |-> i_run_last && i_text_done && (i_out_char == 8'h00))
        else $error("malformed empty result");

    // end of text is also end of the byte's run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_text_done |-> i_run_last)
        else $error("text_done without run_last");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind identifier_case_converter icc_checker u_icc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_char   (o_out.out_char),
    .i_char_valid (o_out.char_valid),
    .i_run_last   (o_out.run_last),
    .i_text_done  (o_out.text_done)
);
`default_nettype wire

// ===== tb/icc_result_checker.sv =====
// Result checker for the identifier case converter testbench.
// Watches the byte and result channels, predicts each result and compares.
// Depends on icc_pkg and the stream interfaces in icc_if.sv.
module icc_result_checker (
    input  wire       i_clk,
    input  wire       i_rst_n,
    icc_in_if         i_in,
    icc_out_if        i_res,
    input  wire       i_cfg_we,
    input  wire [3:0] i_cfg_wdata,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import icc_pkg::*;

    logic [3:0] style_reg;
    logic       prev_lower;
    logic       word_open;
    logic       word_seen;
    int         mismatches;
    t_res       due_results[$];

    function automatic logic upper_letter(input logic [7:0] c);
        return c >= "A" && c <= "Z";
    endfunction

    function automatic logic lower_letter(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic [7:0] raise_letter(input logic [7:0] c);
        return lower_letter(c) ? (c ^ CASE_DELTA) : c;
    endfunction

    function automatic logic [7:0] drop_letter(input logic [7:0] c);
        return upper_letter(c) ? (c ^ CASE_DELTA) : c;
    endfunction

    function automatic t_res char_result(input logic [7:0] c);
        return '{out_char: c, char_valid: 1'b1, run_last: 1'b0, text_done: 1'b0};
    endfunction

    // Works out the results of one accepted byte and queues them.
    task automatic convert_byte(input logic [7:0] ch, input logic last);
        logic       is_sep;
        logic       starts;
        logic       first_word;
        logic       cap;
        logic [7:0] joint;
        t_res       outs[$];
        t_res       tail;
        is_sep     = (ch == CH_UNDERSCORE) || (ch == CH_HYPHEN) || (ch == CH_SPACE);
        starts     = 1'b0;
        first_word = !word_seen;
        cap        = 1'b0;
        joint      = CH_NONE;

        // word tracking runs whatever the style
        if (is_sep) begin
            word_open = 1'b0;
        end else begin
            if (upper_letter(ch) && prev_lower)
                word_open = 1'b0;
            if (!word_open) begin
                starts    = 1'b1;
                word_open = 1'b1;
                word_seen = 1'b1;
            end
        end
        prev_lower = lower_letter(ch);

        case (style_reg)
            STYLE_UPPER: outs.push_back(char_result(raise_letter(ch)));
            STYLE_LOWER: outs.push_back(char_result(drop_letter(ch)));
            STYLE_TITLE, STYLE_CAMEL, STYLE_SNAKE, STYLE_CONSTANT,
            STYLE_KEBAB, STYLE_PASCAL: begin
                if (!is_sep) begin
                    case (style_reg)
                        STYLE_TITLE:                 joint = CH_SPACE;
                        STYLE_SNAKE, STYLE_CONSTANT: joint = CH_UNDERSCORE;
                        STYLE_KEBAB:                 joint = CH_HYPHEN;
                        default:                     joint = CH_NONE;
                    endcase
                    if (starts && !first_word && joint != CH_NONE)
                        outs.push_back(char_result(joint));
                    case (style_reg)
                        STYLE_CONSTANT:           cap = 1'b1;
                        STYLE_SNAKE, STYLE_KEBAB: cap = 1'b0;
                        STYLE_CAMEL:              cap = starts && !first_word;
                        default:                  cap = starts;
                    endcase
                    outs.push_back(char_result(cap ? raise_letter(ch) : drop_letter(ch)));
                end
            end
            default: outs.push_back(char_result(ch));
        endcase

        // a dropped separator closing the text still yields an empty result
        if (outs.size() == 0 && last) begin
            tail = char_result(CH_NONE);
            tail.char_valid = 1'b0;
            outs.push_back(tail);
        end
        if (outs.size() > 0) begin
            tail = outs.pop_back();
            tail.run_last  = 1'b1;
            tail.text_done = last;
            outs.push_back(tail);
        end
        foreach (outs[k])
            due_results.push_back(outs[k]);

        if (last) begin
            prev_lower = 1'b0;
            word_open  = 1'b0;
            word_seen  = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %h/%b/%b/%b", $time,
                     got.out_char, got.char_valid, got.run_last, got.text_done);
        end else begin
            want = due_results.pop_front();
            compare_field("out_char",   want.out_char,   got.out_char);
            compare_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
            compare_field("run_last",   8'(want.run_last),   8'(got.run_last));
            compare_field("text_done",  8'(want.text_done),  8'(got.text_done));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            style_reg  = STYLE_PASS;
            prev_lower = 1'b0;
            word_open  = 1'b0;
            word_seen  = 1'b0;
            mismatches = 0;
            due_results.delete();
        end else begin
            if (i_cfg_we)
                style_reg = i_cfg_wdata;
            if (i_in.valid && i_in.ready)
                convert_byte(i_in.in_char, i_in.text_end);
            if (i_res.valid && i_res.ready)
                check_result('{out_char: i_res.out_char, char_valid: i_res.char_valid,
                               run_last: i_res.run_last, text_done: i_res.text_done});
        end
        o_fail_count <= mismatches;
        o_pending    <= due_results.size();
    end

endmodule

// ===== tb/tb_identifier_case_converter.sv =====
// Testbench top for the identifier case converter.
// Drives bytes, style writes and output backpressure; the result checker predicts and compares.
// Depends on icc_pkg, icc_if.sv, icc_result_checker and the block itself.
module tb_identifier_case_converter;
    timeunit 1ns;
    timeprecision 1ps;
    import icc_pkg::*;

    // Codes outside the defined styles; the block treats them as passthrough.
    localparam logic [3:0] STYLE_UNDEF_LOW  = 4'd9;
    localparam logic [3:0] STYLE_UNDEF_HIGH = 4'd15;

    localparam int PHASES        = 13;
    localparam int PHASE_ITEMS   = 95;
    localparam int HOLD_CYCLES   = 150;  // long receiver hold-off
    localparam int SETTLE_CYCLES = 4;    // covers a dropped byte still in the pipe
    localparam int DRAIN_LIMIT   = 20000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [3:0] cfg_wdata;
    logic       sink_ready = 1'b0;
    logic       sink_steady = 1'b0;  // receiver never idles while set
    logic       hold_start = 1'b0;   // one-cycle request for a long hold-off
    int         hold_left = 0;
    logic       src_gaps;            // sender inserts random idle cycles
    int         fail_count;
    int         pending;

    icc_in_if  in_if ();
    icc_out_if out_if ();

    assign out_if.ready = sink_ready;

    identifier_case_converter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    icc_result_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_if),
        .i_res        (out_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 20 ns clock period.
    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Receiver: a requested hold-off is counted down here, cycle by cycle.
    // Otherwise ready drops in about a quarter of the cycles, unless the
    // steady flag asks for a stretch with no idling.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end else if (hold_start) begin
            sink_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
        end else begin
            sink_ready <= sink_steady || ($urandom_range(99) >= 25);
        end
    end

    // One byte transaction. Gaps come first so that valid is never lowered
    // and raised within one step. Returns at the edge that accepted it.
    task automatic send_byte(input logic [7:0] ch, input logic last);
        while (src_gaps && $urandom_range(99) < 25) begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid    <= 1'b1;
        in_if.in_char  <= ch;
        in_if.text_end <= last;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
    endtask

    // Sends a string; the last byte closes the text if asked.
    task automatic send_text(input string text, input logic closes);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], closes && (i == text.len() - 1));
    endtask

    // Stops offering and waits until every predicted result has been seen,
    // then a few more cycles for a dropped byte that gives no result.
    task automatic settle();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Style write, only ever issued from an idle block.
    task automatic set_style(input logic [3:0] code);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Identifier-like text: mostly letters, some separators and digits,
    // and a fifth of arbitrary bytes so every bit of in_char toggles.
    function automatic logic [7:0] pick_text_byte();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return 8'("a") + 8'($urandom_range(25));
        else if (roll < 55)
            return 8'("A") + 8'($urandom_range(25));
        else if (roll < 70) begin
            case ($urandom_range(2))
                0:       return CH_UNDERSCORE;
                1:       return CH_HYPHEN;
                default: return CH_SPACE;
            endcase
        end else if (roll < 80)
            return 8'("0") + 8'($urandom_range(9));
        else
            return 8'($urandom_range(255));
    endfunction

    // Random texts, mean length about ten bytes. The run may stop mid-text,
    // so the next style applies to a text already under way.
    task automatic send_random_run(input int count);
        for (int k = 0; k < count; k++)
            send_byte(pick_text_byte(), $urandom_range(9) == 0);
    endtask

    initial begin
        int         phase;
        int         drain_cycles;
        logic [3:0] code;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= STYLE_PASS;
        in_if.valid    <= 1'b0;
        in_if.in_char  <= CH_NONE;
        in_if.text_end <= 1'b0;
        src_gaps        = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Style out of reset is passthrough; byte extremes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Letter range borders in the plain case maps.
        set_style(STYLE_UPPER);
        send_text("`az{", 1'b1);
        set_style(STYLE_LOWER);
        send_text("@AZ[", 1'b1);
        // Camel split on lower-to-upper, separator dropped, first word lower.
        set_style(STYLE_CAMEL);
        send_text("aB_c9", 1'b1);
        // Separator as the last byte of a text: one empty result.
        set_style(STYLE_KEBAB);
        send_text("q-", 1'b1);
        // A digit opening a word passes unchanged.
        set_style(STYLE_TITLE);
        send_text("1x", 1'b1);
        set_style(STYLE_PASCAL);
        send_text("hi", 1'b1);
        // Undefined style code acts as passthrough.
        set_style(STYLE_UNDEF_HIGH);
        send_text("aZ", 1'b1);
        // Style changed in the middle of a text keeps the word state.
        set_style(STYLE_SNAKE);
        send_text("aB", 1'b0);
        set_style(STYLE_CONSTANT);
        send_text("cD ", 1'b1);

        // ---- random part ----
        // Every defined style, then both ends of the undefined codes,
        // then random codes.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase <= int'(STYLE_PASS))
                code = phase[3:0];
            else if (phase == int'(STYLE_PASS) + 1)
                code = STYLE_UNDEF_HIGH;
            else if (phase == int'(STYLE_PASS) + 2)
                code = STYLE_UNDEF_LOW;
            else
                code = 4'($urandom_range(15));
            set_style(code);

            if (phase == int'(STYLE_SNAKE)) begin
                // Receiver holds off for a long stretch while the sender
                // keeps offering, so the block fills and stalls its input.
                src_gaps = 1'b0;
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
                send_random_run(PHASE_ITEMS);
                src_gaps = 1'b1;
            end else if (phase == int'(STYLE_KEBAB)) begin
                // Stretch with no idling on either side.
                src_gaps = 1'b0;
                sink_steady <= 1'b1;
                send_random_run(PHASE_ITEMS);
                settle();
                sink_steady <= 1'b0;
                src_gaps = 1'b1;
            end else begin
                send_random_run(PHASE_ITEMS);
            end
        end

        // ---- wind-down ----
        in_if.valid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES * 2) @(posedge clk);

        if (pending != 0)
            $display("%0t: %0d expected results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
